>>> rtl/gvcs_pkg.sv
// ----------------------------------------------------------------------------
// Gear velocity solver package
// Sequencer state codes, Q16.16 constants and the saturating helpers
// used by the gear joint velocity datapath.
// ----------------------------------------------------------------------------
package gvcs_pkg;

  // Q16.16 limits and constants.
  localparam logic signed [31:0] Q_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE     = 32'sd65536;
  localparam logic signed [31:0] SLIP_GAIN = 32'sd262144;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_RATIO = 3'd0;
  localparam logic [2:0] REG_DT    = 3'd1;
  localparam logic [2:0] REG_MAXC  = 3'd2;
  localparam logic [2:0] REG_INV_A = 3'd3;
  localparam logic [2:0] REG_INV_B = 3'd4;
  localparam logic [2:0] REG_INV_C = 3'd5;
  localparam logic [2:0] REG_INV_D = 3'd6;

  // Sequencer states, one-hot.
  typedef enum logic [30:0] {
    ST_IDLE   = 31'd1 << 0,
    ST_W_RR   = 31'd1 << 1,
    ST_W_SUM  = 31'd1 << 2,
    ST_W_K    = 31'd1 << 3,
    ST_W_K2   = 31'd1 << 4,
    ST_W_MDIV = 31'd1 << 5,
    ST_W_CLMP = 31'd1 << 6,
    ST_A_RI   = 31'd1 << 7,
    ST_A_M0   = 31'd1 << 8,
    ST_A_M1   = 31'd1 << 9,
    ST_A_M2   = 31'd1 << 10,
    ST_A_M3   = 31'd1 << 11,
    ST_A_M4   = 31'd1 << 12,
    ST_DONE   = 31'd1 << 13,
    ST_S_DIFF = 31'd1 << 14,
    ST_S_CD   = 31'd1 << 15,
    ST_S_CD2  = 31'd1 << 16,
    ST_S_ABS  = 31'd1 << 17,
    ST_S_DEN  = 31'd1 << 18,
    ST_S_DEN2 = 31'd1 << 19,
    ST_S_SLIP = 31'd1 << 20,
    ST_S_LAM  = 31'd1 << 21,
    ST_S_NEG  = 31'd1 << 22,
    ST_S_MS   = 31'd1 << 23,
    ST_S_CLD  = 31'd1 << 24,
    ST_S_ENG  = 31'd1 << 25,
    ST_S_ENG2 = 31'd1 << 26,
    ST_S_CLB  = 31'd1 << 27,
    ST_S_ACC  = 31'd1 << 28,
    ST_DV_INI = 31'd1 << 29,
    ST_DV_RUN = 31'd1 << 30
  } state_t;

  // Saturate a 48-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = Q_MAX;
    else if (v < -48'sd2147483648) r = Q_MIN;
    else r = v[31:0];
    return r;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) r = v[32] ? Q_MIN : Q_MAX;
    else r = v[31:0];
    return r;
  endfunction

  // Saturating absolute value.
  function automatic logic signed [31:0] abs32(input logic signed [31:0] v);
    logic signed [31:0] r;
    if (v == Q_MIN) r = Q_MAX;
    else if (v < 0) r = -v;
    else r = v;
    return r;
  endfunction

  // Symmetric clamp; the limit is never negative.
  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lim);
    logic signed [31:0] r;
    if (v > lim) r = lim;
    else if (v < -lim) r = -lim;
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/gear_velocity_constraint_solver.sv
// ----------------------------------------------------------------------------
// Gear velocity constraint solver
// Sequential-impulse gear joint solver in Q16.16 with one shared multiplier
// and one shared restoring divider under a one-hot sequencer.
// ----------------------------------------------------------------------------
// A warm-start request makes one divide (none when the mass comes out zero),
// a solve request up to four, all on the shared divider. One request is in
// flight at a time; the output register lets the next request start while a
// result waits.
// Reset: synchronous, restores the register defaults and clears the mass,
// the impulse and out_valid.
module gear_velocity_constraint_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] omega_a,
  input  logic signed [31:0] omega_b,
  input  logic signed [31:0] omega_c,
  input  logic signed [31:0] omega_d,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_omega_a,
  output logic signed [31:0] new_omega_b,
  output logic signed [31:0] new_omega_c,
  output logic signed [31:0] new_omega_d,
  output logic signed [31:0] step_impulse,
  output logic signed [31:0] total_impulse
);

  // Configuration registers.
  logic signed [31:0] ratio;
  logic [16:0]        dt;
  logic [30:0]        maxc;
  logic [30:0]        inv_a;
  logic [30:0]        inv_b;
  logic [30:0]        inv_c;
  logic [30:0]        inv_d;

  // Solver state and working registers.
  gvcs_pkg::state_t   state;
  gvcs_pkg::state_t   div_ret;
  logic signed [31:0] mass;
  logic signed [31:0] acc;
  logic signed [31:0] w0, w1, w2, w3;
  logic signed [31:0] t0, t1, t2;
  logic signed [31:0] lam;
  logic signed [31:0] stp;
  logic signed [31:0] mstep;

  // Divider registers.
  logic [47:0] dn;
  logic [31:0] dd;
  logic [30:0] rem;
  logic [30:0] dq;
  logic [4:0]  dcnt;

  // Shared multiplier: Q16.16 product, floor shift, saturation.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic signed [31:0] qm;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      gvcs_pkg::ST_W_RR:   begin mul_a = ratio; mul_b = ratio; end
      gvcs_pkg::ST_W_K:    begin mul_a = t0; mul_b = t1; end
      gvcs_pkg::ST_A_RI:   begin mul_a = ratio; mul_b = stp; end
      gvcs_pkg::ST_A_M0:   begin mul_a = t0; mul_b = {1'b0, inv_a}; end
      gvcs_pkg::ST_A_M1:   begin mul_a = t0; mul_b = {1'b0, inv_b}; end
      gvcs_pkg::ST_A_M2:   begin mul_a = stp; mul_b = {1'b0, inv_c}; end
      gvcs_pkg::ST_A_M3:   begin mul_a = stp; mul_b = {1'b0, inv_d}; end
      gvcs_pkg::ST_S_CD:   begin mul_a = ratio; mul_b = t0; end
      gvcs_pkg::ST_S_ABS:  begin mul_a = gvcs_pkg::abs32(t0); mul_b = {15'd0, dt}; end
      gvcs_pkg::ST_S_DEN:  begin mul_a = gvcs_pkg::SLIP_GAIN; mul_b = t1; end
      gvcs_pkg::ST_S_SLIP: begin mul_a = mass; mul_b = t0; end
      gvcs_pkg::ST_S_LAM:  begin mul_a = t2; mul_b = t1; end
      gvcs_pkg::ST_S_ENG:  begin mul_a = gvcs_pkg::abs32(ratio); mul_b = {1'b0, inv_b}; end
      default:             begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign qm   = gvcs_pkg::sat48(prod[63:16]);

  // Combinational helpers for the add steps.
  logic signed [31:0] k_sum;
  logic signed [31:0] den_sum;
  logic [23:0]        lim75;
  logic [16:0]        dt_eff;
  logic [31:0]        dv_shift;
  logic [32:0]        dv_trial;
  logic               out_load;

  assign k_sum    = gvcs_pkg::sat33({t0[31], t0} + {t2[31], t2});
  assign den_sum  = gvcs_pkg::sat33({gvcs_pkg::Q_ONE[31], gvcs_pkg::Q_ONE} + {t1[31], t1});
  assign lim75    = {1'b0, dt, 6'd0} + {4'd0, dt, 3'd0} + {6'd0, dt, 1'b0} + {7'd0, dt};
  assign dt_eff   = (dt == 17'd0) ? 17'd1 : dt;
  assign dv_shift = {rem, dn[30]};
  assign dv_trial = {1'b0, dv_shift} - {1'b0, dd};

  assign in_ready = (state == gvcs_pkg::ST_IDLE);
  assign out_load = (state == gvcs_pkg::ST_DONE) && (!out_valid || out_ready);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= 32'sd65536;
      dt    <= 17'd1092;
      maxc  <= 31'd13107;
      inv_a <= 31'd65536;
      inv_b <= 31'd65536;
      inv_c <= 31'd65536;
      inv_d <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        gvcs_pkg::REG_RATIO: ratio <= cfg_data;
        gvcs_pkg::REG_DT:    dt    <= cfg_data[16:0];
        gvcs_pkg::REG_MAXC:  maxc  <= cfg_data[30:0];
        gvcs_pkg::REG_INV_A: inv_a <= cfg_data[30:0];
        gvcs_pkg::REG_INV_B: inv_b <= cfg_data[30:0];
        gvcs_pkg::REG_INV_C: inv_c <= cfg_data[30:0];
        gvcs_pkg::REG_INV_D: inv_d <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared when it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gvcs_pkg::ST_IDLE;
      div_ret   <= gvcs_pkg::ST_IDLE;
      mass      <= '0;
      acc       <= '0;
    end else begin
      case (state)
        gvcs_pkg::ST_IDLE: begin
          if (in_valid) begin
            w0 <= omega_a;
            w1 <= omega_b;
            w2 <= omega_c;
            w3 <= omega_d;
            state <= func ? gvcs_pkg::ST_S_DIFF : gvcs_pkg::ST_W_RR;
          end
        end
        // Warm start: effective mass and clamped stored impulse.
        gvcs_pkg::ST_W_RR: begin
          t0 <= qm;
          state <= gvcs_pkg::ST_W_SUM;
        end
        gvcs_pkg::ST_W_SUM: begin
          t1 <= gvcs_pkg::sat33({2'b00, inv_a} + {2'b00, inv_b});
          t2 <= gvcs_pkg::sat33({2'b00, inv_c} + {2'b00, inv_d});
          state <= gvcs_pkg::ST_W_K;
        end
        gvcs_pkg::ST_W_K: begin
          t0 <= qm;
          state <= gvcs_pkg::ST_W_K2;
        end
        gvcs_pkg::ST_W_K2: begin
          if (k_sum == 32'sd0) begin
            mass  <= '0;
            state <= gvcs_pkg::ST_W_CLMP;
          end else begin
            dn      <= {gvcs_pkg::Q_ONE, 16'd0};
            dd      <= k_sum;
            div_ret <= gvcs_pkg::ST_W_MDIV;
            state   <= gvcs_pkg::ST_DV_INI;
          end
        end
        gvcs_pkg::ST_W_MDIV: begin
          mass  <= {1'b0, dq};
          state <= gvcs_pkg::ST_W_CLMP;
        end
        gvcs_pkg::ST_W_CLMP: begin
          acc   <= gvcs_pkg::clamp32(acc, {8'd0, lim75});
          stp   <= gvcs_pkg::clamp32(acc, {8'd0, lim75});
          state <= gvcs_pkg::ST_A_RI;
        end
        // Apply the impulse to the four velocities.
        gvcs_pkg::ST_A_RI: begin
          t0 <= qm;
          state <= gvcs_pkg::ST_A_M0;
        end
        gvcs_pkg::ST_A_M0: begin
          t1 <= qm;
          state <= gvcs_pkg::ST_A_M1;
        end
        gvcs_pkg::ST_A_M1: begin
          w0 <= gvcs_pkg::sat33({w0[31], w0} - {t1[31], t1});
          t1 <= qm;
          state <= gvcs_pkg::ST_A_M2;
        end
        gvcs_pkg::ST_A_M2: begin
          w1 <= gvcs_pkg::sat33({w1[31], w1} + {t1[31], t1});
          t1 <= qm;
          state <= gvcs_pkg::ST_A_M3;
        end
        gvcs_pkg::ST_A_M3: begin
          w2 <= gvcs_pkg::sat33({w2[31], w2} - {t1[31], t1});
          t1 <= qm;
          state <= gvcs_pkg::ST_A_M4;
        end
        gvcs_pkg::ST_A_M4: begin
          w3 <= gvcs_pkg::sat33({w3[31], w3} + {t1[31], t1});
          state <= gvcs_pkg::ST_DONE;
        end
        // Load the output register once it is free.
        gvcs_pkg::ST_DONE: begin
          if (out_load) begin
            new_omega_a   <= w0;
            new_omega_b   <= w1;
            new_omega_c   <= w2;
            new_omega_d   <= w3;
            step_impulse  <= stp;
            total_impulse <= acc;
            state         <= gvcs_pkg::ST_IDLE;
          end
        end
        // Solve: velocity error and slip scale.
        gvcs_pkg::ST_S_DIFF: begin
          t0 <= gvcs_pkg::sat33({w1[31], w1} - {w0[31], w0});
          t1 <= gvcs_pkg::sat33({w3[31], w3} - {w2[31], w2});
          state <= gvcs_pkg::ST_S_CD;
        end
        gvcs_pkg::ST_S_CD: begin
          t0 <= qm;
          state <= gvcs_pkg::ST_S_CD2;
        end
        gvcs_pkg::ST_S_CD2: begin
          t0 <= gvcs_pkg::sat33({t0[31], t0} + {t1[31], t1});
          state <= gvcs_pkg::ST_S_ABS;
        end
        gvcs_pkg::ST_S_ABS: begin
          t1 <= qm;
          state <= gvcs_pkg::ST_S_DEN;
        end
        gvcs_pkg::ST_S_DEN: begin
          t1 <= qm;
          state <= gvcs_pkg::ST_S_DEN2;
        end
        gvcs_pkg::ST_S_DEN2: begin
          dn      <= {gvcs_pkg::Q_ONE, 16'd0};
          dd      <= den_sum;
          div_ret <= gvcs_pkg::ST_S_SLIP;
          state   <= gvcs_pkg::ST_DV_INI;
        end
        gvcs_pkg::ST_S_SLIP: begin
          t1 <= {1'b0, dq};
          t2 <= qm;
          state <= gvcs_pkg::ST_S_LAM;
        end
        gvcs_pkg::ST_S_LAM: begin
          lam <= qm;
          state <= gvcs_pkg::ST_S_NEG;
        end
        // Negate, then divide for the correction step bound.
        gvcs_pkg::ST_S_NEG: begin
          lam     <= (lam == gvcs_pkg::Q_MIN) ? gvcs_pkg::Q_MAX : -lam;
          dn      <= {2'd0, maxc, 15'd0};
          dd      <= {15'd0, dt_eff};
          div_ret <= gvcs_pkg::ST_S_MS;
          state   <= gvcs_pkg::ST_DV_INI;
        end
        gvcs_pkg::ST_S_MS: begin
          mstep <= {1'b0, dq};
          if (inv_d != 31'd0) begin
            dn      <= {1'b0, dq, 16'd0};
            dd      <= {1'b0, inv_d};
            div_ret <= gvcs_pkg::ST_S_CLD;
            state   <= gvcs_pkg::ST_DV_INI;
          end else begin
            state <= gvcs_pkg::ST_S_ENG;
          end
        end
        gvcs_pkg::ST_S_CLD: begin
          lam   <= gvcs_pkg::clamp32(lam, {1'b0, dq});
          state <= gvcs_pkg::ST_S_ENG;
        end
        // Engine bound from the ratio magnitude.
        gvcs_pkg::ST_S_ENG: begin
          t1 <= qm;
          if (inv_b != 31'd0 && ratio != 32'sd0) state <= gvcs_pkg::ST_S_ENG2;
          else state <= gvcs_pkg::ST_S_ACC;
        end
        gvcs_pkg::ST_S_ENG2: begin
          if (t1 != 32'sd0) begin
            dn      <= {mstep, 16'd0};
            dd      <= t1;
            div_ret <= gvcs_pkg::ST_S_CLB;
            state   <= gvcs_pkg::ST_DV_INI;
          end else begin
            state <= gvcs_pkg::ST_S_ACC;
          end
        end
        gvcs_pkg::ST_S_CLB: begin
          lam   <= gvcs_pkg::clamp32(lam, {1'b0, dq});
          state <= gvcs_pkg::ST_S_ACC;
        end
        gvcs_pkg::ST_S_ACC: begin
          acc   <= gvcs_pkg::sat33({acc[31], acc} + {lam[31], lam});
          stp   <= lam;
          state <= gvcs_pkg::ST_A_RI;
        end
        // Divider: overflow check, then one quotient bit per cycle.
        gvcs_pkg::ST_DV_INI: begin
          if ({15'd0, dn[47:31]} >= dd) begin
            dq    <= '1;
            state <= div_ret;
          end else begin
            rem   <= {14'd0, dn[47:31]};
            dq    <= '0;
            dcnt  <= 5'd31;
            state <= gvcs_pkg::ST_DV_RUN;
          end
        end
        gvcs_pkg::ST_DV_RUN: begin
          if (!dv_trial[32]) begin
            rem <= dv_trial[30:0];
            dq  <= {dq[29:0], 1'b1};
          end else begin
            rem <= dv_shift[30:0];
            dq  <= {dq[29:0], 1'b0};
          end
          dn   <= {dn[46:0], 1'b0};
          dcnt <= dcnt - 5'd1;
          if (dcnt == 5'd1) state <= div_ret;
        end
        default: state <= gvcs_pkg::ST_IDLE;
      endcase
    end
  end

  // An accepted request blocks the input until its result is loaded.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in flight");

  // The divider never runs with an empty count.
  a_dcnt: assert property (@(posedge clk) disable iff (rst)
    state == gvcs_pkg::ST_DV_RUN |-> dcnt != 5'd0)
    else $error("divider running with zero count");

  // The effective mass is never negative.
  a_mass: assert property (@(posedge clk) disable iff (rst)
    !mass[31])
    else $error("negative effective mass");

  // A finished result waits while the output register is held.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    state == gvcs_pkg::ST_DONE && out_valid && !out_ready
      |=> state == gvcs_pkg::ST_DONE && out_valid)
    else $error("result lost while output stalled");

endmodule

>>> sim/gvcs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gear velocity solver checker
// Watches the configuration port and the request and result channels, keeps its own
// copy of the solver state, predicts each result and compares it field by
// field with what the block returns.
// ----------------------------------------------------------------------------
module gvcs_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               func,
  input  logic signed [31:0] omega_a,
  input  logic signed [31:0] omega_b,
  input  logic signed [31:0] omega_c,
  input  logic signed [31:0] omega_d,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] new_omega_a,
  input  logic signed [31:0] new_omega_b,
  input  logic signed [31:0] new_omega_c,
  input  logic signed [31:0] new_omega_d,
  input  logic signed [31:0] step_impulse,
  input  logic signed [31:0] total_impulse,
  output int                 fail_count,
  output int                 outstanding
);

  typedef struct {
    logic signed [31:0] w [4];
    logic signed [31:0] step;
    logic signed [31:0] total;
  } solve_result_t;

  // Mirror of the configuration registers and the solver state.
  longint ratio, dt, max_corr, inv_a, inv_b, inv_c, inv_d;
  longint mass, acc_impulse;
  solve_result_t expected_results[$];

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Product floors toward minus infinity; the arithmetic shift does that.
  function automatic longint qm(input longint a, input longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint qd(input longint a, input longint b);
    return sat((a * 65536) / b);
  endfunction

  function automatic longint qabs(input longint a);
    return (a < 0) ? sat(-a) : a;
  endfunction

  function automatic longint clamp(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Works out the result of one request and advances the mirrored state.
  function automatic solve_result_t predict_velocities(input logic f,
                                                       input longint w0,
                                                       input longint w1,
                                                       input longint w2,
                                                       input longint w3);
    solve_result_t r;
    longint w [4];
    longint k, cdot, den, slip, lambda, dt_eff, max_step, d, bound, ri;
    w[0] = w0; w[1] = w1; w[2] = w2; w[3] = w3;
    if (!f) begin
      k = sat(qm(qm(ratio, ratio), sat(inv_a + inv_b)) + sat(inv_c + inv_d));
      mass = (k > 0) ? qd(65536, k) : 0;
      acc_impulse = clamp(acc_impulse, 75 * dt);
      lambda = acc_impulse;
    end else begin
      cdot = sat(qm(ratio, sat(w[1] - w[0])) + sat(w[3] - w[2]));
      den = sat(65536 + qm(262144, qm(qabs(cdot), dt)));
      slip = qd(65536, den);
      lambda = sat(-qm(qm(mass, cdot), slip));
      dt_eff = (dt > 0) ? dt : 1;
      max_step = sat((max_corr * 32768) / dt_eff);
      if (inv_d > 0) lambda = clamp(lambda, qd(max_step, inv_d));
      if (inv_b > 0 && ratio != 0) begin
        d = qm(qabs(ratio), inv_b);
        bound = (d > 0) ? qd(max_step, d) : 64'sd2147483647;
        lambda = clamp(lambda, bound);
      end
      acc_impulse = sat(acc_impulse + lambda);
    end
    // Apply the impulse to the four bodies.
    ri = qm(ratio, lambda);
    w[0] = sat(w[0] - qm(ri, inv_a));
    w[1] = sat(w[1] + qm(ri, inv_b));
    w[2] = sat(w[2] - qm(lambda, inv_c));
    w[3] = sat(w[3] + qm(lambda, inv_d));
    for (int i = 0; i < 4; i++) r.w[i] = w[i][31:0];
    r.step = lambda[31:0];
    r.total = acc_impulse[31:0];
    return r;
  endfunction

  assign outstanding = expected_results.size();

  always @(posedge clk) begin
    solve_result_t e;
    logic signed [31:0] got [6];
    logic signed [31:0] want [6];
    if (rst) begin
      ratio <= 65536; dt <= 1092; max_corr <= 13107;
      inv_a <= 65536; inv_b <= 65536; inv_c <= 65536; inv_d <= 65536;
      mass = 0;
      acc_impulse = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gvcs_pkg::REG_RATIO: ratio <= longint'($signed(cfg_data));
          gvcs_pkg::REG_DT:    dt <= longint'(cfg_data[16:0]);
          gvcs_pkg::REG_MAXC:  max_corr <= longint'(cfg_data[30:0]);
          gvcs_pkg::REG_INV_A: inv_a <= longint'(cfg_data[30:0]);
          gvcs_pkg::REG_INV_B: inv_b <= longint'(cfg_data[30:0]);
          gvcs_pkg::REG_INV_C: inv_c <= longint'(cfg_data[30:0]);
          gvcs_pkg::REG_INV_D: inv_d <= longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      // Compare a returned result with the oldest prediction.
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("ERROR: result with no request pending");
        end else begin
          e = expected_results.pop_front();
          got = '{new_omega_a, new_omega_b, new_omega_c, new_omega_d,
                  step_impulse, total_impulse};
          want = '{e.w[0], e.w[1], e.w[2], e.w[3], e.step, e.total};
          if (got != want) begin
            fail_count++;
            if (fail_count <= 10)
              for (int i = 0; i < 6; i++)
                if (got[i] != want[i])
                  $display("ERROR: field %0d expected %0d got %0d", i, want[i], got[i]);
          end
        end
      end
      // Predict the result of an accepted request.
      if (in_valid && in_ready)
        expected_results.push_back(predict_velocities(func, omega_a, omega_b,
                                                      omega_c, omega_d));
    end
  end

endmodule

>>> sim/tb_gear_velocity_constraint_solver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gear velocity solver testbench
// Drives directed and random warm-start and solve requests across a range
// of register settings, with random bursts, output stalls and a long
// output hold-off; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_gear_velocity_constraint_solver;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = gvcs_pkg::REG_RATIO;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = 1'b0;
  logic signed [31:0] omega_a = '0, omega_b = '0, omega_c = '0, omega_d = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] new_omega_a, new_omega_b, new_omega_c, new_omega_d;
  logic signed [31:0] step_impulse, total_impulse;
  int                 fail_count;
  int                 outstanding;
  int                 burst_left = 0;
  bit                 hold_go = 0;
  bit                 hold_done = 0;
  int                 hold_left = 0;

  localparam logic FUNC_WARM  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gear_velocity_constraint_solver uut (.*);

  gvcs_checker chk (.*);

  // Receiver: random stall patterns, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      case ((($time / 400) % 3))
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        default: out_ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  // Sends one request and waits for it to be taken.
  task automatic send_request(input logic f, input logic signed [31:0] a,
                              input logic signed [31:0] b,
                              input logic signed [31:0] c,
                              input logic signed [31:0] d);
    in_valid <= 1'b1;
    func <= f;
    omega_a <= a; omega_b <= b; omega_c <= c; omega_d <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Bursts of random length, separated by random gaps.
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // Stops sending and waits for every pending result.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; the write enable is then held low before the task returns.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_omega();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2: return $urandom;
      default: return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endcase
  endfunction

  function automatic logic [31:0] pick_inertia(input int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'd0;
      default: return $urandom_range(0, 4) == 0 ? {1'b0, $urandom} >> 1
                                                : $urandom_range(1024, 262144);
    endcase
  endfunction

  task automatic random_setting(input int mode);
    logic [31:0] ratio;
    case ($urandom_range(0, 5))
      0: ratio = (mode == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: ratio = $urandom;
      2: ratio = 32'd0;
      default: ratio = $signed($urandom_range(0, 262144)) - 131072;
    endcase
    write_reg(gvcs_pkg::REG_RATIO, ratio);
    write_reg(gvcs_pkg::REG_DT, (mode == 0) ? 32'd65536 :
                                (mode == 1) ? 32'd1 : $urandom_range(1, 65536));
    write_reg(gvcs_pkg::REG_MAXC, (mode == 0) ? 32'h7FFF_FFFF :
                                  (mode == 1) ? 32'd0 : $urandom_range(0, 1 << 20));
    write_reg(gvcs_pkg::REG_INV_A, pick_inertia(mode));
    write_reg(gvcs_pkg::REG_INV_B, pick_inertia($urandom_range(0, 5)));
    write_reg(gvcs_pkg::REG_INV_C, pick_inertia(mode));
    write_reg(gvcs_pkg::REG_INV_D, pick_inertia($urandom_range(0, 5)));
  endtask

  // Safety limit on the whole run.
  initial begin
    #8000000;
    $display("gear_velocity_constraint_solver regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, extremes of each field, both operations.
    send_request(FUNC_SOLVE, 0, 0, 0, 0);
    send_request(FUNC_WARM, 0, 0, 0, 0);
    send_request(FUNC_SOLVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(FUNC_SOLVE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_request(FUNC_WARM, 32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1);
    send_request(FUNC_SOLVE, 65536, -65536, 131072, -131072);
    drain();
    // Zero time step, wheel bound off, tiny engine product.
    write_reg(gvcs_pkg::REG_DT, 32'd0);
    write_reg(gvcs_pkg::REG_INV_D, 32'd0);
    write_reg(gvcs_pkg::REG_RATIO, 32'd1);
    write_reg(gvcs_pkg::REG_INV_B, 32'd1);
    send_request(FUNC_WARM, 0, 0, 0, 0);
    send_request(FUNC_SOLVE, 100000, -100000, 50000, -70000);
    drain();
    // Negative ratio, engine bound off by zero ratio and by zero engine inertia.
    write_reg(gvcs_pkg::REG_DT, 32'd1092);
    write_reg(gvcs_pkg::REG_INV_D, 32'd65536);
    write_reg(gvcs_pkg::REG_RATIO, 32'hFFFE_0000);
    send_request(FUNC_WARM, 0, 0, 0, 0);
    send_request(FUNC_SOLVE, 300000, -300000, 10000, 20000);
    drain();
    write_reg(gvcs_pkg::REG_RATIO, 32'd0);
    write_reg(gvcs_pkg::REG_INV_B, 32'd0);
    send_request(FUNC_WARM, 0, 0, 0, 0);
    send_request(FUNC_SOLVE, 300000, -300000, 10000, 20000);
    drain();
    // All-zero inertias give zero mass.
    write_reg(gvcs_pkg::REG_INV_A, 32'd0);
    write_reg(gvcs_pkg::REG_INV_C, 32'd0);
    write_reg(gvcs_pkg::REG_INV_D, 32'd0);
    write_reg(gvcs_pkg::REG_MAXC, 32'h7FFF_FFFF);
    send_request(FUNC_WARM, 5, 6, 7, 8);
    send_request(FUNC_SOLVE, 5, 6, 7, 8);
    drain();

    // Random phases under varied settings, extremes among them.
    for (int phase = 0; phase < 8; phase++) begin
      random_setting(phase < 2 ? phase : 2);
      if (phase == 3) hold_go = 1;
      for (int n = 0; n < 225; n++)
        send_request($urandom_range(0, 3) == 0 ? FUNC_WARM : FUNC_SOLVE,
                     pick_omega(), pick_omega(), pick_omega(), pick_omega());
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("gear_velocity_constraint_solver regression: pass");
    else
      $display("gear_velocity_constraint_solver regression: fail");
    $finish;
  end

endmodule

>>> gear_velocity_constraint_solver.f
rtl/gvcs_pkg.sv
rtl/gear_velocity_constraint_solver.sv
sim/gvcs_checker.sv
sim/tb_gear_velocity_constraint_solver.sv
